FILE: design/lpr_pkg.sv
// Shared constants, types and command struct for the LRU page replacement block.
`default_nettype none

package lpr_pkg;

  // Sizes of the frame table and of the transaction fields.
  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 4;
  localparam int COUNT_W   = 32;

  // Frame count after reset.
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(FRAMES);

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  // Saturation value of the hit and fault counters.
  localparam count_t COUNT_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transaction
    logic exec;    // look up, update the frames and load the result register
    logic cfg_wr;  // write the frame count and start a new string
  } dp_cmd_t;

endpackage

`default_nettype wire

FILE: design/lpr_ctrl.sv
// Controller state machine: sequences capture and execution of each reference.
`default_nettype none

module lpr_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  output lpr_pkg::dp_cmd_t cmd
);
  import lpr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  // The result register is full and is not being taken this cycle.
  assign out_busy  = out_valid_r && out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.cfg_wr    = cfg_valid && cfg_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_busy) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is never written over one that is still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // An accepted transaction moves to the execute state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted transaction not pending execution");

  // Every execution produces a result on the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("execution without a result");

  // Capture and configuration never take place while a reference is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !(cmd.load || cmd.cfg_wr))
    else $error("capture or configuration during execution");

endmodule

`default_nettype wire

FILE: design/lpr_dp.sv
// Datapath: frame table, recency ranks, counters and the result register.
`default_nettype none

module lpr_dp (
  input  wire                             clk,
  input  wire                             rst_n,
  input  lpr_pkg::dp_cmd_t                cmd,
  input  wire [lpr_pkg::PAGE_BITS-1:0]    in_page,
  input  wire                             in_last_in_string,
  input  wire [lpr_pkg::CFG_W-1:0]        cfg_data,
  output logic                            out_hit,
  output logic [lpr_pkg::SLOT_W-1:0]      out_slot,
  output logic                            out_evicted_valid,
  output logic [lpr_pkg::PAGE_BITS-1:0]   out_evicted_page,
  output logic [lpr_pkg::COUNT_W-1:0]     out_hit_count,
  output logic [lpr_pkg::COUNT_W-1:0]     out_fault_count
);
  import lpr_pkg::*;

  // Frame table and string state.
  page_t              frame_page_r [FRAMES];
  logic [FRAMES-1:0]  valid_r, valid_nxt;
  slot_t              rank_r [FRAMES];
  slot_t              rank_nxt [FRAMES];
  count_t             hits_r, hits_nxt;
  count_t             faults_r, faults_nxt;
  cfg_t               frames_r;

  // Captured transaction.
  page_t              page_r;
  logic               last_r;

  // Result register.
  logic               res_hit_r;
  slot_t              res_slot_r;
  logic               res_ev_valid_r;
  page_t              res_ev_page_r;
  count_t             res_hits_r;
  count_t             res_faults_r;

  // Lookup results.
  logic [CNT_W-1:0]   n_act;
  logic [FRAMES-1:0]  active;
  logic [CNT_W-1:0]   count;
  logic               hit;
  slot_t              hit_slot;
  logic               found;
  slot_t              empty_slot;
  slot_t              victim;
  slot_t              victim_rank;
  slot_t              wr_slot;
  slot_t              old_rank;
  logic               evict;

  // Active frame count: zero acts as one, anything above the table acts as the table.
  always_comb begin
    if (frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (frames_r > CFG_W'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(frames_r);
    end
    for (int k = 0; k < FRAMES; k++) begin
      active[k] = (CNT_W'(k) < n_act);
    end
  end

  assign count = CNT_W'($countones(valid_r & active));

  // Lowest-index hit and lowest-index empty slot.
  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    found      = 1'b0;
    empty_slot = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (active[k] && valid_r[k] && (frame_page_r[k] == page_r)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(k);
      end
      if (active[k] && !valid_r[k]) begin
        found      = 1'b1;
        empty_slot = SLOT_W'(k);
      end
    end
  end

  // Least recently used active slot; a tie goes to the lower index.
  always_comb begin
    victim      = '0;
    victim_rank = rank_r[0];
    for (int k = 1; k < FRAMES; k++) begin
      if (active[k] && (rank_r[k] < victim_rank)) begin
        victim      = SLOT_W'(k);
        victim_rank = rank_r[k];
      end
    end
  end

  assign evict    = !hit && !found;
  assign old_rank = rank_r[hit_slot];

  // Slot that receives the reference.
  always_comb begin
    priority if (hit) begin
      wr_slot = hit_slot;
    end else if (found) begin
      wr_slot = empty_slot;
    end else begin
      wr_slot = victim;
    end
  end

  // Rank, valid and counter updates for this reference.
  always_comb begin
    valid_nxt = valid_r;
    for (int k = 0; k < FRAMES; k++) begin
      rank_nxt[k] = rank_r[k];
    end
    hits_nxt   = hits_r;
    faults_nxt = faults_r;
    if (hit) begin
      for (int k = 0; k < FRAMES; k++) begin
        if (active[k] && valid_r[k] && (rank_r[k] > old_rank)) begin
          rank_nxt[k] = rank_r[k] - SLOT_W'(1);
        end
      end
      rank_nxt[hit_slot] = SLOT_W'(count - CNT_W'(1));
      hits_nxt = (hits_r == COUNT_MAX) ? hits_r : hits_r + COUNT_W'(1);
    end else begin
      if (found) begin
        valid_nxt[empty_slot] = 1'b1;
        rank_nxt[empty_slot]  = SLOT_W'(count);
      end else begin
        for (int k = 0; k < FRAMES; k++) begin
          if (active[k] && (SLOT_W'(k) != victim) && (rank_r[k] != '0)) begin
            rank_nxt[k] = rank_r[k] - SLOT_W'(1);
          end
        end
        rank_nxt[victim] = SLOT_W'(n_act - CNT_W'(1));
      end
      faults_nxt = (faults_r == COUNT_MAX) ? faults_r : faults_r + COUNT_W'(1);
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page;
      last_r <= in_last_in_string;
    end
  end

  // String state: cleared by reset, a configuration write or the end of a string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
      valid_r  <= '0;
      hits_r   <= '0;
      faults_r <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        rank_r[k] <= '0;
      end
    end else if (cmd.cfg_wr) begin
      frames_r <= cfg_data;
      valid_r  <= '0;
      hits_r   <= '0;
      faults_r <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        rank_r[k] <= '0;
      end
    end else if (cmd.exec) begin
      if (last_r) begin
        valid_r  <= '0;
        hits_r   <= '0;
        faults_r <= '0;
        for (int k = 0; k < FRAMES; k++) begin
          rank_r[k] <= '0;
        end
      end else begin
        valid_r  <= valid_nxt;
        hits_r   <= hits_nxt;
        faults_r <= faults_nxt;
        for (int k = 0; k < FRAMES; k++) begin
          rank_r[k] <= rank_nxt[k];
        end
      end
    end
  end

  // Page store; entries are only read while their valid bit is set.
  always_ff @(posedge clk) begin
    if (cmd.exec && !hit) begin
      frame_page_r[wr_slot] <= page_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_hit_r      <= hit;
      res_slot_r     <= wr_slot;
      res_ev_valid_r <= evict;
      res_ev_page_r  <= evict ? frame_page_r[victim] : '0;
      res_hits_r     <= hits_nxt;
      res_faults_r   <= faults_nxt;
    end
  end

  assign out_hit           = res_hit_r;
  assign out_slot          = res_slot_r;
  assign out_evicted_valid = res_ev_valid_r;
  assign out_evicted_page  = res_ev_page_r;
  assign out_hit_count     = res_hits_r;
  assign out_fault_count   = res_faults_r;

  // Resident frames always lie inside the active range.
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r & ~active) == '0)
    else $error("valid frame outside the active range");

  // A reference that does not end its string always leaves its page resident.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !last_r && !cmd.cfg_wr) |=> valid_r[$past(wr_slot)])
    else $error("referenced slot not resident after update");

endmodule

`default_nettype wire

FILE: design/lru_page_replacement.sv
// Top level of the LRU page replacement block: controller and datapath.
//
// Usage: each input transaction carries a page reference (in_page) and an
// end-of-string flag (in_last_in_string). Every reference produces exactly
// one result transaction with the hit flag, the frame slot now holding the
// page, the evicted page if a resident page was replaced, and the saturating
// hit and fault counts of the current string including this reference.
// Both channels use valid and stall; a transaction moves on a rising edge
// with valid high and stall low. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) writes the frame count and starts a new string; it
// is accepted only while no reference is pending.
// Each reference is captured in the idle state; the frame lookup, rank update
// and result load follow in the execute state. A new reference is not accepted
// until the previous one has been executed.
// When the receiver stalls, the result is held and the next reference is
// still accepted, then waits in the execute state until the result is taken.
// Reset empties all frames, clears ranks and counters, and sets the frame
// count to eight.
`default_nettype none

module lru_page_replacement (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [lpr_pkg::PAGE_BITS-1:0]    in_page,
  input  wire                             in_last_in_string,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_hit,
  output logic [lpr_pkg::SLOT_W-1:0]      out_slot,
  output logic                            out_evicted_valid,
  output logic [lpr_pkg::PAGE_BITS-1:0]   out_evicted_page,
  output logic [lpr_pkg::COUNT_W-1:0]     out_hit_count,
  output logic [lpr_pkg::COUNT_W-1:0]     out_fault_count,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [lpr_pkg::CFG_W-1:0]        cfg_data
);
  import lpr_pkg::*;

  dp_cmd_t cmd;

  // Sequencing of capture, execution and configuration.
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Frame table, ranks, counters and result register.
  lpr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_page),
    .in_last_in_string (in_last_in_string),
    .cfg_data          (cfg_data),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_count     (out_hit_count),
    .out_fault_count   (out_fault_count)
  );

endmodule

`default_nettype wire
